@@ sv/ggps_pkg.sv @@
package ggps_pkg;

    // Fixed field widths of the request and response transactions
    localparam int NODE_FW   = 5;
    localparam int WEIGHT_FW = 16;
    localparam int STATUS_W  = 3;

    // Request mode
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PATH     = 3'd0,
        ST_STORED   = 3'd1,
        ST_REJECTED = 3'd2,
        ST_NOPATH   = 3'd3,
        ST_BADEND   = 3'd4
    } t_status;

    // Control from the sequencer to the best-neighbour unit
    typedef struct packed {
        logic clr;  // forget the current best candidate
        logic smp;  // weight from the store is valid this cycle
    } t_scan_ctl;

endpackage

@@ sv/ggps_if.sv @@
// Request channel: one edge load or one search per transaction
interface ggps_req_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [ggps_pkg::NODE_FW-1:0]   from_node;
    logic [ggps_pkg::NODE_FW-1:0]   to_node;
    logic [ggps_pkg::WEIGHT_FW-1:0] edge_weight;
    logic [ggps_pkg::NODE_FW-1:0]   start_node;
    logic [ggps_pkg::NODE_FW-1:0]   finish_node;

    modport source (
        output valid, mode, from_node, to_node, edge_weight, start_node, finish_node,
        input  ready
    );
    modport sink (
        input  valid, mode, from_node, to_node, edge_weight, start_node, finish_node,
        output ready
    );
endinterface

// Response channel: path nodes or a single status word
interface ggps_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ggps_pkg::NODE_FW-1:0]  path_node;
    logic                          last;
    logic [ggps_pkg::STATUS_W-1:0] status;

    modport source (
        output valid, path_node, last, status,
        input  ready
    );
    modport sink (
        input  valid, path_node, last, status,
        output ready
    );
endinterface

@@ sv/ggps_ram.sv @@
// Simple dual-port RAM, one write and one registered read per cycle
module ggps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 676
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ggps_best.sv @@
// Running minimum over one row of the weight store: smallest nonzero
// weight to an unvisited node, first index kept on ties
module ggps_best #(
    parameter int NW = 5,
    parameter int WB = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ggps_pkg::t_scan_ctl i_ctl,
    input  logic [NW-1:0]       i_col,
    input  logic [WB-1:0]       i_weight,
    input  logic                i_visited,
    output logic                o_found,
    output logic [NW-1:0]       o_pick
);

    logic          r_found;
    logic [WB-1:0] r_best;
    logic [NW-1:0] r_pick;
    logic          w_take;

    // strict compare keeps the lower index on equal weights
    assign w_take = i_ctl.smp && (i_weight != '0) && !i_visited
                    && (!r_found || (i_weight < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best <= i_weight;
            r_pick <= i_col;
        end
    end

    assign o_found = r_found;
    assign o_pick  = r_pick;

endmodule

@@ sv/greedy_graph_path_search_top.sv @@
// Greedy path search over a directed weighted graph held in an on-chip
// adjacency RAM of NODE_COUNT x NODE_COUNT weights. After reset the block
// first zeroes that RAM, one entry a cycle, and accepts no request until
// that clearing pass is done. A valid edge load writes the RAM as it is
// taken, and every load then presents its status. A search walks the store
// row by row: each step reads the used part of the current node's row
// through the single RAM read port, a backtrack reads the path stack for
// the node below, and the found path leaves node by node, each read from
// the path stack. One request is in flight at a time and the next is taken
// once the final response is in the output register.
module greedy_graph_path_search_top #(
    parameter int NODE_COUNT  = 26,
    parameter int WEIGHT_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ggps_req_if.sink   i_req,
    ggps_rsp_if.source o_rsp
);

    localparam int NW      = $clog2(NODE_COUNT);
    localparam int CW      = $clog2(NODE_COUNT + 1);
    localparam int AW      = $clog2(NODE_COUNT * NODE_COUNT);
    localparam int NODE_FW = ggps_pkg::NODE_FW;

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_RESP    = 7'b0000100,
        S_SCAN    = 7'b0001000,
        S_POP     = 7'b0010000,
        S_EMIT_RD = 7'b0100000,
        S_EMIT_WR = 7'b1000000
    } t_state;

    t_state                    r_state, n_state;
    logic [AW-1:0]             r_clr, n_clr;
    logic [CW-1:0]             r_used, n_used;
    logic [NODE_COUNT-1:0]     r_visited, n_visited;
    logic [CW-1:0]             r_depth, n_depth;
    logic [NW-1:0]             r_cur, n_cur;
    logic [NW-1:0]             r_finish, n_finish;
    logic [CW-1:0]             r_col, n_col;
    logic                      r_rd_v, n_rd_v;
    logic [NW-1:0]             r_rd_col, n_rd_col;
    logic [NW-1:0]             r_idx, n_idx;
    ggps_pkg::t_status         r_resp, n_resp;
    logic                      r_o_valid, n_o_valid;
    logic [NODE_FW-1:0]        r_o_node, n_o_node;
    logic                      r_o_last, n_o_last;
    ggps_pkg::t_status         r_o_status, n_o_status;

    // RAM ports
    logic                   w_w_we;
    logic [AW-1:0]          w_w_waddr;
    logic [WEIGHT_BITS-1:0] w_w_wdata;
    logic [AW-1:0]          w_w_raddr;
    logic [WEIGHT_BITS-1:0] w_w_rdata;
    logic                   w_s_we;
    logic [NW-1:0]          w_s_waddr;
    logic [NW-1:0]          w_s_wdata;
    logic [NW-1:0]          w_s_raddr;
    logic [NW-1:0]          w_s_rdata;

    ggps_pkg::t_scan_ctl    w_ctl;
    logic                   w_found;
    logic [NW-1:0]          w_pick;

    logic                   w_acc;
    logic                   w_out_free;
    logic                   w_last;
    logic                   w_load_ok;
    logic                   w_srch_ok;
    logic [NW-1:0]          w_from, w_to, w_start, w_fin;
    logic [CW-1:0]          w_top;

    // Weight store, zeroed by the clearing pass after reset
    ggps_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (NODE_COUNT * NODE_COUNT)
    ) u_wstore (
        .i_clk   (i_clk),
        .i_we    (w_w_we),
        .i_waddr (w_w_waddr),
        .i_wdata (w_w_wdata),
        .i_raddr (w_w_raddr),
        .o_rdata (w_w_rdata)
    );

    // Path stack, every entry written before it is read
    ggps_ram #(
        .WIDTH (NW),
        .DEPTH (NODE_COUNT)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (w_s_waddr),
        .i_wdata (w_s_wdata),
        .i_raddr (w_s_raddr),
        .o_rdata (w_s_rdata)
    );

    ggps_best #(
        .NW (NW),
        .WB (WEIGHT_BITS)
    ) u_best (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_col     (r_rd_col),
        .i_weight  (w_w_rdata),
        .i_visited (r_visited[r_rd_col]),
        .o_found   (w_found),
        .o_pick    (w_pick)
    );

    // Handshake and request decode
    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_o_valid || o_rsp.ready;

    assign w_from  = NW'(i_req.from_node);
    assign w_to    = NW'(i_req.to_node);
    assign w_start = NW'(i_req.start_node);
    assign w_fin   = NW'(i_req.finish_node);

    assign w_load_ok = (32'(i_req.from_node) < NODE_COUNT)
                       && (32'(i_req.to_node) < NODE_COUNT);
    assign w_srch_ok = (32'(i_req.start_node) < NODE_COUNT)
                       && (32'(i_req.finish_node) < NODE_COUNT);
    assign w_top     = (i_req.from_node > i_req.to_node)
                       ? CW'(i_req.from_node) + CW'(1)
                       : CW'(i_req.to_node) + CW'(1);

    // Row read for the scan; the stack is read at the index during output
    // and at the entry below the top when backtracking
    assign w_w_raddr = AW'(r_cur) * AW'(NODE_COUNT) + AW'(r_col[NW-1:0]);
    assign w_s_raddr = ((r_state == S_EMIT_RD) || (r_state == S_EMIT_WR))
                       ? r_idx : NW'(r_depth - CW'(2));

    assign w_last = ((CW'(r_idx) + CW'(1)) == r_depth);

    // Sequencer. Loads and scans never overlap, so no scan read of the weight
    // RAM hits an entry in the cycle it is written.
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_used     = r_used;
        n_visited  = r_visited;
        n_depth    = r_depth;
        n_cur      = r_cur;
        n_finish   = r_finish;
        n_col      = r_col;
        n_rd_v     = 1'b0;
        n_rd_col   = r_rd_col;
        n_idx      = r_idx;
        n_resp     = r_resp;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_node   = r_o_node;
        n_o_last   = r_o_last;
        n_o_status = r_o_status;
        w_w_we     = 1'b0;
        w_w_waddr  = r_clr;
        w_w_wdata  = '0;
        w_s_we     = 1'b0;
        w_s_waddr  = r_depth[NW-1:0];
        w_s_wdata  = w_pick;
        w_ctl      = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_w_we = 1'b1;
                if (r_clr == AW'(NODE_COUNT * NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end

            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_RESP;
                    if (i_req.mode == ggps_pkg::MODE_LOAD) begin
                        if (w_load_ok) begin
                            w_w_we    = 1'b1;
                            w_w_waddr = AW'(w_from) * AW'(NODE_COUNT) + AW'(w_to);
                            w_w_wdata = WEIGHT_BITS'(i_req.edge_weight);
                            if (w_top > r_used) begin
                                n_used = w_top;
                            end
                            n_resp = ggps_pkg::ST_STORED;
                        end else begin
                            n_resp = ggps_pkg::ST_REJECTED;
                        end
                    end else if (!w_srch_ok) begin
                        n_resp = ggps_pkg::ST_BADEND;
                    end else begin
                        n_visited          = '0;
                        n_visited[w_start] = 1'b1;
                        w_s_we             = 1'b1;
                        w_s_waddr          = '0;
                        w_s_wdata          = w_start;
                        n_depth            = CW'(1);
                        n_cur              = w_start;
                        n_finish           = w_fin;
                        n_col              = '0;
                        n_idx              = '0;
                        w_ctl.clr          = 1'b1;
                        n_state            = (w_start == w_fin) ? S_EMIT_RD : S_SCAN;
                    end
                end
            end

            S_RESP: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_node   = '0;
                    n_o_last   = 1'b1;
                    n_o_status = r_resp;
                    n_state    = S_IDLE;
                end
            end

            S_SCAN: begin
                w_ctl.smp = r_rd_v;
                if (r_col < r_used) begin
                    // issue the next column of the current row
                    n_col    = r_col + CW'(1);
                    n_rd_v   = 1'b1;
                    n_rd_col = r_col[NW-1:0];
                end else if (!r_rd_v) begin
                    // row done: advance or backtrack
                    n_col     = '0;
                    w_ctl.clr = 1'b1;
                    if (w_found) begin
                        w_s_we            = 1'b1;
                        n_depth           = r_depth + CW'(1);
                        n_visited[w_pick] = 1'b1;
                        n_cur             = w_pick;
                        if (w_pick == r_finish) begin
                            n_idx   = '0;
                            n_state = S_EMIT_RD;
                        end
                    end else begin
                        n_depth = r_depth - CW'(1);
                        if (r_depth == CW'(1)) begin
                            n_resp  = ggps_pkg::ST_NOPATH;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_POP;
                        end
                    end
                end
            end

            S_POP: begin
                n_cur   = w_s_rdata;
                n_state = S_SCAN;
            end

            S_EMIT_RD: begin
                n_state = S_EMIT_WR;
            end

            S_EMIT_WR: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_node   = NODE_FW'(w_s_rdata);
                    n_o_last   = w_last;
                    n_o_status = ggps_pkg::ST_PATH;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + NW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_used    <= '0;
            r_depth   <= '0;
            r_col     <= '0;
            r_rd_v    <= 1'b0;
            r_visited <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_used    <= n_used;
            r_depth   <= n_depth;
            r_col     <= n_col;
            r_rd_v    <= n_rd_v;
            r_visited <= n_visited;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_finish   <= n_finish;
        r_rd_col   <= n_rd_col;
        r_idx      <= n_idx;
        r_resp     <= n_resp;
        r_o_node   <= n_o_node;
        r_o_last   <= n_o_last;
        r_o_status <= n_o_status;
    end

    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.path_node = r_o_node;
    assign o_rsp.last      = r_o_last;
    assign o_rsp.status    = r_o_status;

endmodule

@@ sv/ggps_checker.sv @@
// Port-level checks for the path search block
module ggps_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ggps_pkg::NODE_FW-1:0]  i_out_node,
    input logic                          i_out_last,
    input logic [ggps_pkg::STATUS_W-1:0] i_out_status
);

    // Status responses are always single, final transactions
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ggps_pkg::ST_PATH) |-> i_out_last)
        else $error("status response without last");

    // No new request is taken while a path is still being sent
    a_no_accept_mid_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("request ready in the middle of a path");

    // Store clearing follows reset, so no request is taken right away
    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !i_in_ready)
        else $error("ready during clearing pass");

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_node)
        && $stable(i_out_last) && $stable(i_out_status))
        else $error("response changed while stalled");

endmodule

bind greedy_graph_path_search_top ggps_checker u_ggps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_node   (o_rsp.path_node),
    .i_out_last   (o_rsp.last),
    .i_out_status (o_rsp.status)
);

@@ verif/greedy_graph_path_search_top_tb.sv @@
module greedy_graph_path_search_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES        = 26;
    localparam int WBITS        = 16;
    localparam int NODE_W       = ggps_pkg::NODE_FW;
    localparam int WEIGHT_W     = ggps_pkg::WEIGHT_FW;
    // slowest request: scanning, backtracking, then up to 26 stalled path results
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int ITEM_TARGET  = 120;

    typedef struct {
        logic                mode;
        logic [NODE_W-1:0]   src_node;
        logic [NODE_W-1:0]   dst_node;
        logic [WEIGHT_W-1:0] weight;
        logic [NODE_W-1:0]   start_node;
        logic [NODE_W-1:0]   finish_node;
    } t_req;

    typedef struct {
        logic [NODE_W-1:0] node;
        logic              last;
        ggps_pkg::t_status status;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    ggps_req_if req_if ();
    ggps_rsp_if rsp_if ();

    greedy_graph_path_search_top #(
        .NODE_COUNT  (NODES),
        .WEIGHT_BITS (WBITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Stimulus and expected responses
    t_req        request_q[$];
    t_rsp        rsp_due_q[$];
    t_req        cur_req;
    int unsigned n_total;
    int unsigned n_accepted;
    int unsigned n_rsp_seen;
    int unsigned n_errors;
    int unsigned cycle_cnt;
    int unsigned send_gap;
    int unsigned stall_left;

    // Shadow of the graph store, empty after reset
    bit [WBITS-1:0] weight_mem [NODES][NODES];
    int unsigned    used_nodes;

    // Coverage tallies for the summary
    int unsigned n_loads, n_rejects, n_searches, n_found, n_nopath, n_badend, longest;

    // Clock and reset; every input known from time zero
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        req_if.valid       = 1'b0;
        req_if.mode        = ggps_pkg::MODE_LOAD;
        req_if.from_node   = '0;
        req_if.to_node     = '0;
        req_if.edge_weight = '0;
        req_if.start_node  = '0;
        req_if.finish_node = '0;
        rsp_if.ready       = 1'b0;
        fork
            forever #1 i_clk = ~i_clk;
            begin
                repeat (10) @(posedge i_clk);
                i_rst_n <= 1'b1;
            end
        join_none
    end

    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // Idle lengths: mostly none or short, now and then long; calm stretches have none
    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (cycle_cnt[10:9] == 2'b00) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    function automatic void push_rsp(input int unsigned node, input logic last,
                                     input ggps_pkg::t_status status);
        t_rsp r;
        r.node   = node[NODE_W-1:0];
        r.last   = last;
        r.status = status;
        rsp_due_q.push_back(r);
    endfunction

    // Greedy walk over the shadow store, backtracking at dead ends
    function automatic void predict_search(input logic [NODE_W-1:0] s,
                                           input logic [NODE_W-1:0] f);
        int unsigned      cur, depth, pick, c, i;
        logic [WBITS-1:0] best;
        bit               found, dead;
        logic [NODES-1:0] seen;
        int unsigned      trail [NODES];
        n_searches++;
        if (s >= NODES || f >= NODES) begin
            push_rsp(0, 1'b1, ggps_pkg::ST_BADEND);
            n_badend++;
            return;
        end
        seen     = '0;
        seen[s]  = 1'b1;
        trail[0] = s;
        depth    = 1;
        cur      = s;
        dead     = 1'b0;
        while (cur != f && !dead) begin
            found = 1'b0;
            best  = '0;
            pick  = 0;
            for (c = 0; c < used_nodes; c++) begin
                if (weight_mem[cur][c] != 0 && !seen[c] &&
                    (!found || weight_mem[cur][c] < best)) begin
                    found = 1'b1;
                    best  = weight_mem[cur][c];
                    pick  = c;
                end
            end
            if (found) begin
                trail[depth] = pick;
                depth++;
                seen[pick] = 1'b1;
                cur = pick;
            end else begin
                depth--;
                if (depth == 0) dead = 1'b1;
                else cur = trail[depth-1];
            end
        end
        if (dead) begin
            push_rsp(0, 1'b1, ggps_pkg::ST_NOPATH);
            n_nopath++;
        end else begin
            for (i = 0; i < depth; i++)
                push_rsp(trail[i], i + 1 == depth, ggps_pkg::ST_PATH);
            n_found++;
            if (depth > longest) longest = depth;
        end
    endfunction

    function automatic void predict_request(input t_req q);
        int unsigned top;
        if (q.mode == ggps_pkg::MODE_SEARCH) begin
            predict_search(q.start_node, q.finish_node);
            return;
        end
        n_loads++;
        if (q.src_node >= NODES || q.dst_node >= NODES) begin
            push_rsp(0, 1'b1, ggps_pkg::ST_REJECTED);
            n_rejects++;
            return;
        end
        weight_mem[q.src_node][q.dst_node] = q.weight[WBITS-1:0];
        top = ((q.src_node > q.dst_node) ? q.src_node : q.dst_node) + 1;
        if (top > used_nodes) used_nodes = top;
        push_rsp(0, 1'b1, ggps_pkg::ST_STORED);
    endfunction

    // Unused fields of each request carry random noise
    function automatic void push_load(input int unsigned s, input int unsigned d,
                                      input int unsigned w);
        t_req q;
        q.mode        = ggps_pkg::MODE_LOAD;
        q.src_node    = s[NODE_W-1:0];
        q.dst_node    = d[NODE_W-1:0];
        q.weight      = w[WEIGHT_W-1:0];
        q.start_node  = NODE_W'($urandom_range(0, 31));
        q.finish_node = NODE_W'($urandom_range(0, 31));
        request_q.push_back(q);
    endfunction

    function automatic void push_search(input int unsigned s, input int unsigned f);
        t_req q;
        q.mode        = ggps_pkg::MODE_SEARCH;
        q.src_node    = NODE_W'($urandom_range(0, 31));
        q.dst_node    = NODE_W'($urandom_range(0, 31));
        q.weight      = WEIGHT_W'($urandom_range(0, 16'hFFFF));
        q.start_node  = s[NODE_W-1:0];
        q.finish_node = f[NODE_W-1:0];
        request_q.push_back(q);
    endfunction

    // Mostly a dense low corner for long walks, some anywhere, a few out of range
    function automatic int unsigned pick_node();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)  return $urandom_range(NODES, 31);
        if (r < 60) return $urandom_range(0, 9);
        return $urandom_range(0, NODES - 1);
    endfunction

    // Small weights make ties likely; zero removes an edge
    function automatic int unsigned pick_weight();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 50) return $urandom_range(1, 4);
        return $urandom_range(0, 16'hFFFF);
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap     = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_request(cur_req);
                n_accepted++;
                send_gap = random_gap();
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    cur_req = request_q.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.mode        <= cur_req.mode;
                    req_if.from_node   <= cur_req.src_node;
                    req_if.to_node     <= cur_req.dst_node;
                    req_if.edge_weight <= cur_req.weight;
                    req_if.start_node  <= cur_req.start_node;
                    req_if.finish_node <= cur_req.finish_node;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and back-pressure
    always @(posedge i_clk) begin
        t_rsp want;
        cycle_cnt++;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left   = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_rsp_seen++;
                if (rsp_due_q.size() == 0) begin
                    log_error($sformatf("response %0d with none expected: node %0d status %0d",
                                        n_rsp_seen, rsp_if.path_node, rsp_if.status));
                end else begin
                    want = rsp_due_q.pop_front();
                    if (rsp_if.path_node !== want.node)
                        log_error($sformatf("response %0d path_node: expected %0d got %0d",
                                            n_rsp_seen, want.node, rsp_if.path_node));
                    if (rsp_if.last !== want.last)
                        log_error($sformatf("response %0d last: expected %0d got %0d",
                                            n_rsp_seen, want.last, rsp_if.last));
                    if (rsp_if.status !== want.status)
                        log_error($sformatf("response %0d status: expected %0d got %0d",
                                            n_rsp_seen, want.status, rsp_if.status));
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                stall_left = random_gap();
            end
        end
    end

    // Timeout watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d of %0d requests taken",
                 cycle_cnt, n_accepted, n_total);
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus, end of run and verdict
    initial begin
        int unsigned perm [NODES];
        int unsigned i, j, t, k, len, first, prev, nxt, r;

        // empty graph: trivial path, no path, bad endpoints, rejected edges
        push_search(0, 0);
        push_search(0, 1);
        push_search(26, 3);
        push_search(2, 31);
        push_load(26, 0, 5);
        push_load(0, 31, 5);
        // small graph, lightest edge wins
        push_load(0, 1, 16'hFFFF);
        push_load(0, 2, 1);
        push_load(2, 3, 5);
        push_load(1, 3, 1);
        push_search(0, 3);
        // equal weights, self loop, dead end with backtrack
        push_load(3, 4, 7);
        push_load(3, 5, 7);
        push_load(4, 4, 1);
        push_search(3, 5);
        // start above the used count has nothing to scan
        push_search(20, 21);
        // zero weight removes an edge
        push_load(0, 2, 0);
        push_search(0, 5);
        // top node index, then a search that empties the stack
        push_load(25, 24, 1);
        push_load(5, 25, 16'h8000);
        push_search(0, 24);
        push_search(5, 0);
        push_load(31, 31, 16'hFFFF);
        push_search(24, 24);

        // one chain through every node for the longest possible path
        for (i = 0; i < NODES; i++) perm[i] = i;
        for (i = NODES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i]; perm[i] = perm[j]; perm[j] = t;
        end
        for (i = 0; i + 1 < NODES; i++) push_load(perm[i], perm[i+1], 1);
        push_search(perm[0], perm[NODES-1]);

        // random episodes: chains then a search along them, plus noise
        while (request_q.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                len   = $urandom_range(2, 6);
                first = pick_node();
                prev  = first;
                for (k = 0; k < len; k++) begin
                    nxt = pick_node();
                    push_load(prev, nxt, $urandom_range(1, 16'hFFFF));
                    prev = nxt;
                end
                push_search(first, prev);
            end else if (r < 80) begin
                push_load(pick_node(), pick_node(), pick_weight());
            end else begin
                push_search(pick_node(), pick_node());
            end
        end
        n_total = request_q.size();

        while (n_accepted < n_total || rsp_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rsp_due_q.size() != 0)
            log_error($sformatf("%0d expected responses never arrived", rsp_due_q.size()));

        $display("Covered %0d edge loads (%0d rejected) and %0d searches in %0d cycles",
                 n_loads, n_rejects, n_searches, cycle_cnt);
        $display("Searches: %0d paths (longest %0d nodes), %0d no path, %0d bad endpoints",
                 n_found, longest, n_nopath, n_badend);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
